### hdl/aqpd_pkg.sv
package aqpd_pkg;

   // Default formats and loop lengths
   localparam int QUAT_FRAC_BITS_DEF   = 14;
   localparam int ANGLE_ITERATIONS_DEF = 16;

   // Angle constants in Q3.13 and Q30 radians
   localparam int ANG_LIM   = 25736;
   localparam int PITCH_LIM = 12868;
   localparam logic signed [34:0] PI_Q30 = 35'sd3373259426;

   // CORDIC datapath widths
   localparam int CORDIC_XY_W = 38;
   localparam int CORDIC_Z_W  = 35;

   // Square root of a Q60 radicand, one result bit per stage
   localparam int SQRT_STEPS = 31;
   localparam int SQRT_W     = 62;

   // Flags that ride along with a word through the angle stages
   typedef struct packed {
      logic valid;
      logic settled;
      logic sat;
   } ctl_type;

   // Word carried through the square root stages
   typedef struct packed {
      logic               valid;
      logic               settled;
      logic               sat;
      logic signed [34:0] roll_y;
      logic signed [34:0] roll_x;
      logic signed [34:0] yaw_y;
      logic signed [34:0] yaw_x;
      logic signed [31:0] s30;
   } side_type;

   // atan(2^-i) in units of 2^-30 rad
   function automatic logic [29:0] atan_q30(input logic [4:0] i);
      logic [29:0] v;
      case (i)
         5'd0:  v = 30'd843314857;
         5'd1:  v = 30'd497837829;
         5'd2:  v = 30'd263043837;
         5'd3:  v = 30'd133525159;
         5'd4:  v = 30'd67021687;
         5'd5:  v = 30'd33543516;
         5'd6:  v = 30'd16775851;
         5'd7:  v = 30'd8388437;
         5'd8:  v = 30'd4194283;
         5'd9:  v = 30'd2097149;
         5'd10: v = 30'd1048576;
         5'd11: v = 30'd524288;
         5'd12: v = 30'd262144;
         5'd13: v = 30'd131072;
         5'd14: v = 30'd65536;
         5'd15: v = 30'd32768;
         5'd16: v = 30'd16384;
         5'd17: v = 30'd8192;
         5'd18: v = 30'd4096;
         5'd19: v = 30'd2048;
         5'd20: v = 30'd1024;
         5'd21: v = 30'd512;
         5'd22: v = 30'd256;
         5'd23: v = 30'd128;
         5'd24: v = 30'd64;
         5'd25: v = 30'd32;
         5'd26: v = 30'd16;
         5'd27: v = 30'd8;
         5'd28: v = 30'd4;
         5'd29: v = 30'd2;
         5'd30: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

### hdl/aqpd_req_if.sv
interface aqpd_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] meas_w;
   logic signed [15:0] meas_x;
   logic signed [15:0] meas_y;
   logic signed [15:0] meas_z;
   logic signed [15:0] rate_x;
   logic signed [15:0] rate_y;
   logic signed [15:0] rate_z;

   modport source (output valid, meas_w, meas_x, meas_y, meas_z, rate_x, rate_y, rate_z,
                   input ready);
   modport sink (input valid, meas_w, meas_x, meas_y, meas_z, rate_x, rate_y, rate_z,
                 output ready);
endinterface

### hdl/aqpd_rsp_if.sv
interface aqpd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] cmd_roll;
   logic signed [14:0] cmd_pitch;
   logic signed [15:0] cmd_yaw;
   logic               within_tolerance;
   logic               saturated;

   modport source (output valid, cmd_roll, cmd_pitch, cmd_yaw, within_tolerance, saturated,
                   input ready);
   modport sink (input valid, cmd_roll, cmd_pitch, cmd_yaw, within_tolerance, saturated,
                 output ready);
endinterface

### hdl/aqpd_cordic.sv
module aqpd_cordic
   import aqpd_pkg::*;
#(
   parameter int ITERATIONS = ANGLE_ITERATIONS_DEF,
   parameter int LIMIT      = ANG_LIM
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  ctl_type                       in_ctl,
   input  logic signed [CORDIC_XY_W-1:0] y_in,
   input  logic signed [CORDIC_XY_W-1:0] x_in,
   output ctl_type                       out_ctl,
   output logic signed [15:0]            angle
);

   localparam int XY_W = CORDIC_XY_W;
   localparam int Z_W  = CORDIC_Z_W;
   localparam int R_W  = Z_W - 17;

   ctl_type                ctl_ff  [0:ITERATIONS];
   logic                   zero_ff [0:ITERATIONS];
   logic signed [XY_W-1:0] x_ff    [0:ITERATIONS];
   logic signed [XY_W-1:0] y_ff    [0:ITERATIONS];
   logic signed [Z_W-1:0]  z_ff    [0:ITERATIONS];

   logic                   zero_in;
   logic signed [XY_W-1:0] x_in0;
   logic signed [XY_W-1:0] y_in0;
   logic signed [Z_W-1:0]  z_in0;

   // Fold the left half plane onto the right and note the origin
   always_comb begin
      zero_in = (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
         x_in0 = -x_in;
         y_in0 = -y_in;
         z_in0 = (y_in >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
         x_in0 = x_in;
         y_in0 = y_in;
         z_in0 = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (adv) begin
         ctl_ff[0] <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zero_ff[0] <= zero_in;
         x_ff[0]    <= x_in0;
         y_ff[0]    <= y_in0;
         z_ff[0]    <= z_in0;
      end
   end

   // One rotation per stage
   for (genvar i = 0; i < ITERATIONS; i++) begin : g_step
      logic signed [XY_W-1:0] dx;
      logic signed [XY_W-1:0] dy;
      logic signed [Z_W-1:0]  da;
      logic signed [XY_W-1:0] x_in;
      logic signed [XY_W-1:0] y_in;
      logic signed [Z_W-1:0]  z_in;

      always_comb begin
         dx = y_ff[i] >>> i;
         dy = x_ff[i] >>> i;
         da = Z_W'($signed({1'b0, atan_q30(5'(i))}));
         if (y_ff[i] > 0) begin
            x_in = x_ff[i] + dx;
            y_in = y_ff[i] - dy;
            z_in = z_ff[i] + da;
         end else begin
            x_in = x_ff[i] - dx;
            y_in = y_ff[i] + dy;
            z_in = z_ff[i] - da;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[i+1] <= '0;
         end else if (adv) begin
            ctl_ff[i+1] <= ctl_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            zero_ff[i+1] <= zero_ff[i];
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            z_ff[i+1]    <= z_in;
         end
      end
   end

   logic signed [Z_W-1:0] z_rnd;
   logic signed [R_W-1:0] a_rnd;

   // Round to Q3.13 and clamp to the angle range
   always_comb begin
      z_rnd = z_ff[ITERATIONS] + Z_W'(65536);
      a_rnd = R_W'(z_rnd >>> 17);
      if (zero_ff[ITERATIONS]) begin
         angle = '0;
      end else if (a_rnd > R_W'(LIMIT)) begin
         angle = 16'(LIMIT);
      end else if (a_rnd < -R_W'(LIMIT)) begin
         angle = -16'(LIMIT);
      end else begin
         angle = 16'(a_rnd);
      end
   end

   assign out_ctl = ctl_ff[ITERATIONS];

endmodule

### hdl/attitude_quaternion_pd_control_core.sv
// Quaternion feedback attitude controller.
// Input channel req_ch carries one measured attitude quaternion (Q2.14) and
// three body rates (Q4.12) per word. Output channel rsp_ch returns one word
// per input word, in order: roll, pitch and yaw commands in Q3.13, the
// settled flag and the clamp flag. Both channels move a word when valid and
// ready are high at a rising clock edge.
// The csr port writes the reference quaternion, the two gains and the settle
// limit; write only while no word is in flight.
// The path from input to output has seven arithmetic stages, one stage per
// bit of the 31-bit square root used for pitch, one CORDIC pre-rotation
// stage plus one stage per CORDIC iteration, and the output register. One
// word enters per cycle while the output is not stalled.
// When the receiver holds rsp_ch.ready low with a word waiting, the whole
// pipeline holds and req_ch.ready drops; nothing is lost or repeated.
// Reset (synchronous, active high) empties the pipeline and loads the
// default register values.
module attitude_quaternion_pd_control_core
   import aqpd_pkg::*;
#(
   parameter int QUAT_FRAC_BITS   = QUAT_FRAC_BITS_DEF,
   parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   aqpd_req_if.sink    req_ch,
   aqpd_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam logic [2:0] REG_REF_W    = 3'd0;
   localparam logic [2:0] REG_REF_X    = 3'd1;
   localparam logic [2:0] REG_REF_Y    = 3'd2;
   localparam logic [2:0] REG_REF_Z    = 3'd3;
   localparam logic [2:0] REG_ATT_GAIN = 3'd4;
   localparam logic [2:0] REG_RATE_GAIN = 3'd5;
   localparam logic [2:0] REG_SETTLE   = 3'd6;

   localparam int F     = QUAT_FRAC_BITS;
   localparam int ERR_W = 35 - F;
   localparam int PK_W  = ERR_W + 17;
   localparam int PR_W  = 33;
   localparam int A1_W  = PK_W + 12;
   localparam int A2_W  = PR_W + F;
   localparam int ACC_W = ((A1_W > A2_W) ? A1_W : A2_W) + 2;
   localparam int SH_R  = (2 * F >= 30) ? (2 * F - 30) : 0;
   localparam int SH_L  = (2 * F >= 30) ? 0 : (30 - 2 * F);
   localparam logic signed [63:0] S_LIM = 64'sd1 <<< (2 * F);

   // Configuration registers
   logic signed [15:0] ref_w_ff, ref_x_ff, ref_y_ff, ref_z_ff, settle_ff;
   logic        [15:0] att_gain_ff, rate_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_w_ff     <= 16'sd16384;
         ref_x_ff     <= '0;
         ref_y_ff     <= '0;
         ref_z_ff     <= '0;
         att_gain_ff  <= 16'd5120;
         rate_gain_ff <= 16'd1024;
         settle_ff    <= 16'sd3277;
      end else if (csr_we) begin
         case (csr_index)
            REG_REF_W:     ref_w_ff     <= csr_data;
            REG_REF_X:     ref_x_ff     <= csr_data;
            REG_REF_Y:     ref_y_ff     <= csr_data;
            REG_REF_Z:     ref_z_ff     <= csr_data;
            REG_ATT_GAIN:  att_gain_ff  <= csr_data;
            REG_RATE_GAIN: rate_gain_ff <= csr_data;
            REG_SETTLE:    settle_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // Global advance: hold everything while a finished word waits
   logic rsp_valid_ff;
   logic adv;

   assign adv          = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // Stage A: sixteen products of the error quaternion
   logic               a_valid_ff;
   logic signed [31:0] a_prod_ff [4][4];
   logic signed [31:0] a_prod_in [4][4];
   logic signed [15:0] a_rate_ff [3];

   always_comb begin
      a_prod_in[0][0] = ref_w_ff * req_ch.meas_w;
      a_prod_in[0][1] = ref_x_ff * req_ch.meas_x;
      a_prod_in[0][2] = ref_y_ff * req_ch.meas_y;
      a_prod_in[0][3] = ref_z_ff * req_ch.meas_z;
      a_prod_in[1][0] = ref_w_ff * req_ch.meas_x;
      a_prod_in[1][1] = ref_x_ff * req_ch.meas_w;
      a_prod_in[1][2] = ref_y_ff * req_ch.meas_z;
      a_prod_in[1][3] = ref_z_ff * req_ch.meas_y;
      a_prod_in[2][0] = ref_w_ff * req_ch.meas_y;
      a_prod_in[2][1] = ref_x_ff * req_ch.meas_z;
      a_prod_in[2][2] = ref_y_ff * req_ch.meas_w;
      a_prod_in[2][3] = ref_z_ff * req_ch.meas_x;
      a_prod_in[3][0] = ref_w_ff * req_ch.meas_z;
      a_prod_in[3][1] = ref_x_ff * req_ch.meas_y;
      a_prod_in[3][2] = ref_y_ff * req_ch.meas_x;
      a_prod_in[3][3] = ref_z_ff * req_ch.meas_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_prod_ff    <= a_prod_in;
         a_rate_ff[0] <= req_ch.rate_x;
         a_rate_ff[1] <= req_ch.rate_y;
         a_rate_ff[2] <= req_ch.rate_z;
      end
   end

   // Stage B: sum, scale, take the shorter rotation, compare to the limit
   logic                   b_valid_ff, b_within_ff;
   logic signed [ERR_W-1:0] b_err_ff [4];
   logic signed [15:0]     b_rate_ff [3];
   logic signed [33:0]     b_sum [4];
   logic signed [ERR_W-1:0] b_err_in [4];
   logic                   b_within_in;

   always_comb begin
      b_sum[0] = 34'(a_prod_ff[0][0]) + 34'(a_prod_ff[0][1])
               + 34'(a_prod_ff[0][2]) + 34'(a_prod_ff[0][3]);
      b_sum[1] = -34'(a_prod_ff[1][0]) + 34'(a_prod_ff[1][1])
               - 34'(a_prod_ff[1][2]) + 34'(a_prod_ff[1][3]);
      b_sum[2] = -34'(a_prod_ff[2][0]) + 34'(a_prod_ff[2][1])
               + 34'(a_prod_ff[2][2]) - 34'(a_prod_ff[2][3]);
      b_sum[3] = -34'(a_prod_ff[3][0]) - 34'(a_prod_ff[3][1])
               + 34'(a_prod_ff[3][2]) + 34'(a_prod_ff[3][3]);
      for (int q = 0; q < 4; q++) begin
         b_err_in[q] = ERR_W'(b_sum[q] >>> F);
      end
      if (b_err_in[0] < 0) begin
         for (int q = 1; q < 4; q++) begin
            b_err_in[q] = -b_err_in[q];
         end
      end
      b_within_in = 36'(b_err_in[0]) < 36'(settle_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_err_ff    <= b_err_in;
         b_within_ff <= b_within_in;
         b_rate_ff   <= a_rate_ff;
      end
   end

   // Stage C: gain products
   logic                    c_valid_ff, c_within_ff;
   logic signed [ERR_W-1:0] c_w_ff;
   logic signed [PK_W-1:0]  c_pk_ff [3];
   logic signed [PR_W-1:0]  c_pr_ff [3];
   logic signed [PK_W-1:0]  c_pk_in [3];
   logic signed [PR_W-1:0]  c_pr_in [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         c_pk_in[k] = PK_W'($signed({1'b0, att_gain_ff}) * b_err_ff[k+1]);
         c_pr_in[k] = PR_W'($signed({1'b0, rate_gain_ff}) * b_rate_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_pk_ff     <= c_pk_in;
         c_pr_ff     <= c_pr_in;
         c_w_ff      <= b_err_ff[0];
         c_within_ff <= b_within_ff;
      end
   end

   // Stage D: control vector, scale and saturate to 16 bits
   logic               d_valid_ff, d_within_ff, d_sat_ff;
   logic signed [15:0] d_w_ff;
   logic signed [15:0] d_u_ff [3];
   logic signed [ACC_W-1:0] d_acc [3];
   logic signed [ACC_W-1:0] d_sh [3];
   logic signed [15:0] d_u_in [3];
   logic signed [15:0] d_w_in;
   logic signed [35:0] d_w_ext;
   logic               d_sat_in;

   always_comb begin
      d_sat_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         d_acc[k] = -(ACC_W'(c_pk_ff[k]) <<< 12) - (ACC_W'(c_pr_ff[k]) <<< F);
         d_sh[k]  = d_acc[k] >>> 20;
         if (d_sh[k] > ACC_W'(32767)) begin
            d_u_in[k] = 16'sd32767;
            d_sat_in  = 1'b1;
         end else if (d_sh[k] < -ACC_W'(32768)) begin
            d_u_in[k] = -16'sd32768;
            d_sat_in  = 1'b1;
         end else begin
            d_u_in[k] = 16'(d_sh[k]);
         end
      end
      d_w_ext = 36'(c_w_ff);
      if (d_w_ext > 36'sd32767) begin
         d_w_in   = 16'sd32767;
         d_sat_in = 1'b1;
      end else if (d_w_ext < -36'sd32768) begin
         d_w_in   = -16'sd32768;
         d_sat_in = 1'b1;
      end else begin
         d_w_in = 16'(d_w_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (adv) begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_w_ff      <= d_w_in;
         d_u_ff      <= d_u_in;
         d_sat_ff    <= d_sat_in;
         d_within_ff <= c_within_ff;
      end
   end

   // Stage E: squares and cross products of the control quaternion
   logic               e_valid_ff, e_within_ff, e_sat_ff;
   logic signed [31:0] e_ww_ff, e_xx_ff, e_yy_ff, e_zz_ff;
   logic signed [31:0] e_wx_ff, e_yz_ff, e_wz_ff, e_xy_ff, e_wy_ff, e_zx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (adv) begin
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_ww_ff     <= d_w_ff * d_w_ff;
         e_xx_ff     <= d_u_ff[0] * d_u_ff[0];
         e_yy_ff     <= d_u_ff[1] * d_u_ff[1];
         e_zz_ff     <= d_u_ff[2] * d_u_ff[2];
         e_wx_ff     <= d_w_ff * d_u_ff[0];
         e_yz_ff     <= d_u_ff[1] * d_u_ff[2];
         e_wz_ff     <= d_w_ff * d_u_ff[2];
         e_xy_ff     <= d_u_ff[0] * d_u_ff[1];
         e_wy_ff     <= d_w_ff * d_u_ff[1];
         e_zx_ff     <= d_u_ff[2] * d_u_ff[0];
         e_within_ff <= d_within_ff;
         e_sat_ff    <= d_sat_ff;
      end
   end

   // Stage F: angle operands, clamp the sine and rescale it to Q1.30
   side_type           f_side_ff;
   side_type           f_side_in;
   logic signed [34:0] f_s;
   logic signed [63:0] f_s_ext;
   logic signed [63:0] f_s_clamp;

   always_comb begin
      f_side_in.valid   = e_valid_ff;
      f_side_in.settled = e_within_ff;
      f_side_in.roll_y  = (35'(e_wx_ff) + 35'(e_yz_ff)) <<< 1;
      f_side_in.roll_x  = 35'(e_ww_ff) - 35'(e_xx_ff) - 35'(e_yy_ff) + 35'(e_zz_ff);
      f_side_in.yaw_y   = (35'(e_wz_ff) + 35'(e_xy_ff)) <<< 1;
      f_side_in.yaw_x   = 35'(e_ww_ff) + 35'(e_xx_ff) - 35'(e_yy_ff) - 35'(e_zz_ff);
      f_s               = (35'(e_wy_ff) - 35'(e_zx_ff)) <<< 1;
      f_s_ext           = 64'(f_s);
      f_side_in.sat     = e_sat_ff;
      if (f_s_ext > S_LIM) begin
         f_s_clamp     = S_LIM;
         f_side_in.sat = 1'b1;
      end else if (f_s_ext < -S_LIM) begin
         f_s_clamp     = -S_LIM;
         f_side_in.sat = 1'b1;
      end else begin
         f_s_clamp = f_s_ext;
      end
      f_side_in.s30 = 32'((f_s_clamp >>> SH_R) <<< SH_L);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_side_ff.valid <= 1'b0;
      end else if (adv) begin
         f_side_ff.valid <= f_side_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_side_ff.settled <= f_side_in.settled;
         f_side_ff.sat     <= f_side_in.sat;
         f_side_ff.roll_y  <= f_side_in.roll_y;
         f_side_ff.roll_x  <= f_side_in.roll_x;
         f_side_ff.yaw_y   <= f_side_in.yaw_y;
         f_side_ff.yaw_x   <= f_side_in.yaw_x;
         f_side_ff.s30     <= f_side_in.s30;
      end
   end

   // Stage G: square of the sine
   side_type            g_side_ff;
   logic [SQRT_W-1:0]   g_sq_ff;
   logic signed [63:0]  g_sq_in;

   assign g_sq_in = f_side_ff.s30 * f_side_ff.s30;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_side_ff.valid <= 1'b0;
      end else if (adv) begin
         g_side_ff.valid <= f_side_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_side_ff.settled <= f_side_ff.settled;
         g_side_ff.sat     <= f_side_ff.sat;
         g_side_ff.roll_y  <= f_side_ff.roll_y;
         g_side_ff.roll_x  <= f_side_ff.roll_x;
         g_side_ff.yaw_y   <= f_side_ff.yaw_y;
         g_side_ff.yaw_x   <= f_side_ff.yaw_x;
         g_side_ff.s30     <= f_side_ff.s30;
         g_sq_ff           <= SQRT_W'(g_sq_in);
      end
   end

   // Square root stages: cosine = sqrt(2^60 - s^2), one root bit per stage
   side_type          q_side_ff [0:SQRT_STEPS-1];
   logic [SQRT_W-1:0] q_v_ff    [0:SQRT_STEPS-1];
   logic [SQRT_W-1:0] q_r_ff    [0:SQRT_STEPS-1];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (60 - 2 * k);
      side_type          side_prev;
      logic [SQRT_W-1:0] v_prev, r_prev, t, v_in, r_in;

      always_comb begin
         if (k == 0) begin
            side_prev = g_side_ff;
            v_prev    = (SQRT_W'(1) << 60) - g_sq_ff;
            r_prev    = '0;
         end else begin
            side_prev = q_side_ff[(k == 0) ? 0 : k - 1];
            v_prev    = q_v_ff[(k == 0) ? 0 : k - 1];
            r_prev    = q_r_ff[(k == 0) ? 0 : k - 1];
         end
         t = r_prev + BIT;
         if (v_prev >= t) begin
            v_in = v_prev - t;
            r_in = (r_prev >> 1) + BIT;
         end else begin
            v_in = v_prev;
            r_in = r_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            q_side_ff[k].valid <= 1'b0;
         end else if (adv) begin
            q_side_ff[k].valid <= side_prev.valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            q_side_ff[k].settled <= side_prev.settled;
            q_side_ff[k].sat     <= side_prev.sat;
            q_side_ff[k].roll_y  <= side_prev.roll_y;
            q_side_ff[k].roll_x  <= side_prev.roll_x;
            q_side_ff[k].yaw_y   <= side_prev.yaw_y;
            q_side_ff[k].yaw_x   <= side_prev.yaw_x;
            q_side_ff[k].s30     <= side_prev.s30;
            q_v_ff[k]            <= v_in;
            q_r_ff[k]            <= r_in;
         end
      end
   end

   // Angle units
   side_type                      q_last;
   ctl_type                       cor_ctl_in;
   ctl_type                       pitch_ctl;
   logic signed [CORDIC_XY_W-1:0] pitch_c;
   logic signed [15:0]            roll_ang, pitch_ang, yaw_ang;

   assign q_last             = q_side_ff[SQRT_STEPS-1];
   assign cor_ctl_in.valid   = q_last.valid;
   assign cor_ctl_in.settled = q_last.settled;
   assign cor_ctl_in.sat     = q_last.sat;
   assign pitch_c = CORDIC_XY_W'($signed({1'b0, q_r_ff[SQRT_STEPS-1][30:0]}));

   aqpd_cordic #(
      .ITERATIONS (ANGLE_ITERATIONS),
      .LIMIT      (ANG_LIM)
   ) u_roll (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_ctl  (cor_ctl_in),
      .y_in    (CORDIC_XY_W'(q_last.roll_y)),
      .x_in    (CORDIC_XY_W'(q_last.roll_x)),
      .out_ctl (),
      .angle   (roll_ang)
   );

   aqpd_cordic #(
      .ITERATIONS (ANGLE_ITERATIONS),
      .LIMIT      (ANG_LIM)
   ) u_yaw (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_ctl  (cor_ctl_in),
      .y_in    (CORDIC_XY_W'(q_last.yaw_y)),
      .x_in    (CORDIC_XY_W'(q_last.yaw_x)),
      .out_ctl (),
      .angle   (yaw_ang)
   );

   aqpd_cordic #(
      .ITERATIONS (ANGLE_ITERATIONS),
      .LIMIT      (PITCH_LIM)
   ) u_pitch (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_ctl  (cor_ctl_in),
      .y_in    (CORDIC_XY_W'(q_last.s30)),
      .x_in    (pitch_c),
      .out_ctl (pitch_ctl),
      .angle   (pitch_ang)
   );

   // Output register
   logic signed [15:0] rsp_roll_ff, rsp_yaw_ff;
   logic signed [14:0] rsp_pitch_ff;
   logic               rsp_within_ff, rsp_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= pitch_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_roll_ff   <= roll_ang;
         rsp_pitch_ff  <= 15'(pitch_ang);
         rsp_yaw_ff    <= yaw_ang;
         rsp_within_ff <= pitch_ctl.settled;
         rsp_sat_ff    <= pitch_ctl.sat;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.cmd_roll         = rsp_roll_ff;
   assign rsp_ch.cmd_pitch        = rsp_pitch_ff;
   assign rsp_ch.cmd_yaw          = rsp_yaw_ff;
   assign rsp_ch.within_tolerance = rsp_within_ff;
   assign rsp_ch.saturated        = rsp_sat_ff;

`ifndef ASSERT_OFF
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("input taken while output stalled");

   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.cmd_roll <= 16'sd25736 && rsp_ch.cmd_roll >= -16'sd25736))
      else $error("roll command out of range");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.cmd_pitch <= 15'sd12868 && rsp_ch.cmd_pitch >= -15'sd12868))
      else $error("pitch command out of range");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("output word present after reset");
`endif

endmodule
